>>> hw/rtl/dhgd_pkg.sv
package dhgd_pkg;

	localparam int unsigned IdW       = 12;
	localparam int unsigned ZW        = 12;
	localparam int unsigned CxW       = 15;
	localparam int unsigned CyW       = 14;
	localparam int unsigned HrW       = 20;
	localparam int unsigned InDataW   = 16;
	localparam int unsigned OutDataW  = 88;
	localparam int unsigned OutUserW  = 3;
	localparam int unsigned NumRegs   = 7;
	localparam int unsigned RegIdxW   = 3;
	localparam int unsigned AddrW     = 5;

	// channel map
	localparam logic [IdW-1:0] TRK_FIRST = 12'd1;
	localparam logic [IdW-1:0] TRK_LAST  = 12'd1952;
	localparam logic [IdW-1:0] FIB_FIRST = 12'd2001;
	localparam logic [IdW-1:0] FIB_LAST  = 12'd2052;
	localparam logic [IdW-1:0] TOF_FIRST = 12'd2053;
	localparam logic [IdW-1:0] TOF_LAST  = 12'd2070;

	localparam logic [10:0] STATION_1 = 11'd488;
	localparam logic [10:0] STATION_2 = 11'd976;
	localparam logic [10:0] STATION_3 = 11'd1464;
	localparam logic [8:0]  LAYER_1   = 9'd122;
	localparam logic [8:0]  LAYER_2   = 9'd244;
	localparam logic [8:0]  LAYER_3   = 9'd366;
	localparam logic [5:0]  STRIPS_PER_WALL = 6'd26;

	// geometry, 0.01 cm
	localparam logic signed [14:0] LX_ORIGIN   = -15'sd4840;
	localparam logic signed [14:0] LX_STAGGER  = 15'sd40;
	localparam logic [12:0]        STRAW_HW    = 13'd40;
	localparam logic [12:0]        STRAW_HL    = 13'd4500;
	localparam logic [12:0]        STEREO_HR   = 13'd3182;
	localparam logic signed [31:0] STEREO_MUL  = 32'sd46341;
	localparam logic signed [31:0] STEREO_RND  = 32'sd32768;
	localparam logic [12:0]        STRIP_NARROW = 13'd150;
	localparam logic [12:0]        STRIP_WIDE   = 13'd300;
	localparam logic signed [14:0] TOF_X0      = -15'sd9600;
	localparam logic signed [14:0] TOF_PITCH   = 15'sd1200;
	localparam logic signed [13:0] TOF_Y       = 14'sd7200;
	localparam logic [4:0]         TOF_BAR_LOW = 5'd8;
	localparam logic [4:0]         TOF_BAR_HIGH = 5'd9;
	localparam logic [12:0]        TOF_HW      = 13'd600;
	localparam logic [12:0]        TOF_HY      = 13'd1000;
	localparam logic [HrW-1:0]     UNCONSTRAINED = 20'd999900;

	// register indexes
	localparam logic [RegIdxW-1:0] CFG_Z_TRK0 = 3'd0;
	localparam logic [RegIdxW-1:0] CFG_Z_TRK1 = 3'd1;
	localparam logic [RegIdxW-1:0] CFG_Z_TRK2 = 3'd2;
	localparam logic [RegIdxW-1:0] CFG_Z_TRK3 = 3'd3;
	localparam logic [RegIdxW-1:0] CFG_Z_FIB0 = 3'd4;
	localparam logic [RegIdxW-1:0] CFG_Z_FIB1 = 3'd5;
	localparam logic [RegIdxW-1:0] CFG_Z_TOF  = 3'd6;
	localparam logic [RegIdxW-1:0] CFG_NONE   = 3'd7;

	typedef enum logic [1:0] {
		REGION_NONE    = 2'd0,
		REGION_TRACKER = 2'd1,
		REGION_FIBRE   = 2'd2,
		REGION_TIMING  = 2'd3
	} region_t;

	function automatic logic signed [13:0] strip_centre(input logic [4:0] strip);
		logic signed [13:0] c;
		case (strip)
			5'd0:  c = -14'sd6600;
			5'd1:  c = -14'sd6000;
			5'd2:  c = -14'sd5400;
			5'd3:  c = -14'sd4800;
			5'd4:  c = -14'sd4200;
			5'd5:  c = -14'sd3600;
			5'd6:  c = -14'sd3000;
			5'd7:  c = -14'sd2400;
			5'd8:  c = -14'sd1800;
			5'd9:  c = -14'sd1200;
			5'd10: c = -14'sd750;
			5'd11: c = -14'sd450;
			5'd12: c = -14'sd150;
			5'd13: c = 14'sd150;
			5'd14: c = 14'sd450;
			5'd15: c = 14'sd750;
			5'd16: c = 14'sd1200;
			5'd17: c = 14'sd1800;
			5'd18: c = 14'sd2400;
			5'd19: c = 14'sd3000;
			5'd20: c = 14'sd3600;
			5'd21: c = 14'sd4200;
			5'd22: c = 14'sd4800;
			5'd23: c = 14'sd5400;
			5'd24: c = 14'sd6000;
			5'd25: c = 14'sd6600;
			default: c = 14'sd0;
		endcase
		return c;
	endfunction

	function automatic logic [12:0] strip_half_len(input logic [4:0] strip);
		logic [12:0] h;
		case (strip)
			5'd0, 5'd25:  h = 13'd3725;
			5'd1, 5'd24:  h = 13'd4275;
			5'd2, 5'd23:  h = 13'd5375;
			5'd3, 5'd4, 5'd21, 5'd22: h = 13'd5925;
			5'd5, 5'd20:  h = 13'd6475;
			default:      h = 13'd7025;
		endcase
		return h;
	endfunction

endpackage

>>> hw/rtl/detector_hit_geometry_decode.sv
// Detector hit geometry decoder.
// Input stream (s_t*): one channel number per transaction in s_tdata[11:0].
// Output stream (m_t*): one decoded region per input transaction, in order.
// m_tdata carries centre, half ranges and plane z; m_tuser carries the valid
// flag and the region code. Lengths are in 0.01 cm, plane z in cm.
// Plane z registers sit on the APB port at byte addresses 0x00..0x18; a zero
// value disables the plane. Write them only while the stream is idle.
// Pipeline: decode ranges, build local coordinate and table lookups, stereo
// multiply, then the output register that picks z and the final values.
// An input transaction is registered in stages 1, 2, 3 and 4 in order before
// it leaves as an output transaction; throughput is one transaction per cycle
// while m_tready stays high, set by the four-stage pipeline with one multiplier.
// Each stage holds its item while the next one is full and stalled, so a
// stalled receiver fills the pipeline and then drops s_tready; empty stages
// keep taking new items while the output waits.
// Reset clears all stage valid flags and all plane z registers (all planes
// disabled, every hit decodes as invalid until configured).
module detector_hit_geometry_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: channel_id[11:0], zero pad [15:12]
	input  logic [dhgd_pkg::InDataW-1:0]      s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// m_tdata: centre_x[14:0], centre_y[28:15], half_range_x[48:29],
	// half_range_y[68:49], plane_z[80:69], zero pad [87:81]
	output logic [dhgd_pkg::OutDataW-1:0]     m_tdata,
	// m_tuser: hit_valid[0], region[2:1]
	output logic [dhgd_pkg::OutUserW-1:0]     m_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dhgd_pkg::AddrW-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import dhgd_pkg::*;

	// configuration
	logic [ZW-1:0]      zreg_q [NumRegs];
	logic [ZW-1:0]      rdata_q;
	logic [RegIdxW-1:0] cfg_idx;

	assign cfg_idx = paddr[AddrW-1:2];
	assign pready  = 1'b1;
	assign prdata  = {20'd0, rdata_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NumRegs; k++) zreg_q[k] <= '0;
		end else if (psel && penable && pwrite && pready && cfg_idx != CFG_NONE) begin
			zreg_q[cfg_idx] <= pwdata[ZW-1:0];
		end
	end

	// capture read data in the setup cycle
	always_ff @(posedge clk) begin
		if (psel && !penable) begin
			rdata_q <= (cfg_idx == CFG_NONE) ? '0 : zreg_q[cfg_idx];
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !valid_s4 || m_tready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: range decode
	logic [IdW-1:0] id;
	logic [10:0]    id1;
	logic [10:0]    base;
	logic [1:0]     station;
	logic [5:0]     fib_off;
	logic           fib_wall;
	region_t        region_c1;

	region_t        region_s1;
	logic [1:0]     station_s1;
	logic [8:0]     straw_s1;
	logic           wall_s1;
	logic [4:0]     strip_s1;
	logic [4:0]     bar_s1;

	assign id       = s_tdata[IdW-1:0];
	assign id1      = 11'(id - TRK_FIRST);
	assign fib_off  = 6'(id - FIB_FIRST);
	assign fib_wall = fib_off >= STRIPS_PER_WALL;

	always_comb begin
		if (id1 >= STATION_3) begin
			station = 2'd3;
			base    = STATION_3;
		end else if (id1 >= STATION_2) begin
			station = 2'd2;
			base    = STATION_2;
		end else if (id1 >= STATION_1) begin
			station = 2'd1;
			base    = STATION_1;
		end else begin
			station = 2'd0;
			base    = '0;
		end
		if (id >= TRK_FIRST && id <= TRK_LAST) region_c1 = REGION_TRACKER;
		else if (id >= FIB_FIRST && id <= FIB_LAST) region_c1 = REGION_FIBRE;
		else if (id >= TOF_FIRST && id <= TOF_LAST) region_c1 = REGION_TIMING;
		else region_c1 = REGION_NONE;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			region_s1  <= region_c1;
			station_s1 <= station;
			straw_s1   <= 9'(id1 - base);
			wall_s1    <= fib_wall;
			strip_s1   <= 5'(fib_wall ? fib_off - STRIPS_PER_WALL : fib_off);
			bar_s1     <= 5'(id - TOF_FIRST);
		end
	end

	// stage 2: local coordinate, strip tables, bar position
	logic [1:0]          sub;
	logic [8:0]          layer_base;
	logic [6:0]          straw_idx;
	logic signed [14:0]  lx;
	logic signed [13:0]  fc;
	logic [12:0]         fhw;
	logic [12:0]         fhl;
	logic signed [14:0]  cx_c2;
	logic signed [13:0]  cy_c2;
	logic [12:0]         hx_c2;
	logic [12:0]         hy_c2;
	logic                stereo_c2;
	logic                neg_c2;
	logic [RegIdxW-1:0]  zsel_c2;

	region_t             region_s2;
	logic signed [14:0]  cx_s2;
	logic signed [13:0]  cy_s2;
	logic [12:0]         hx_s2;
	logic [12:0]         hy_s2;
	logic signed [13:0]  lx_s2;
	logic                stereo_s2;
	logic                neg_s2;
	logic [RegIdxW-1:0]  zsel_s2;

	always_comb begin
		if (straw_s1 >= LAYER_3) begin
			sub        = 2'd3;
			layer_base = LAYER_3;
		end else if (straw_s1 >= LAYER_2) begin
			sub        = 2'd2;
			layer_base = LAYER_2;
		end else if (straw_s1 >= LAYER_1) begin
			sub        = 2'd1;
			layer_base = LAYER_1;
		end else begin
			sub        = 2'd0;
			layer_base = '0;
		end
		straw_idx = 7'(straw_s1 - layer_base);
		// pitch 80 = 64 + 16; odd sub-layers shift by half a pitch
		lx = LX_ORIGIN + 15'($signed({1'b0, straw_idx, 6'd0}))
			+ 15'($signed({1'b0, straw_idx, 4'd0}))
			+ (sub[0] ? LX_STAGGER : 15'sd0);

		fc  = strip_centre(strip_s1);
		fhl = strip_half_len(strip_s1);
		fhw = (strip_s1 >= 5'd10 && strip_s1 <= 5'd15) ? STRIP_NARROW : STRIP_WIDE;

		cx_c2     = '0;
		cy_c2     = '0;
		hx_c2     = '0;
		hy_c2     = '0;
		stereo_c2 = 1'b0;
		neg_c2    = 1'b0;
		zsel_c2   = CFG_NONE;
		case (region_s1)
			REGION_TRACKER: begin
				zsel_c2 = {1'b0, station_s1};
				case (station_s1)
					2'd0: begin
						cx_c2 = lx;
						hx_c2 = STRAW_HW;
						hy_c2 = STRAW_HL;
					end
					2'd1: begin
						cy_c2 = 14'(lx);
						hx_c2 = STRAW_HL;
						hy_c2 = STRAW_HW;
					end
					default: begin
						stereo_c2 = 1'b1;
						neg_c2    = station_s1 == 2'd3;
						hx_c2     = STEREO_HR;
						hy_c2     = STEREO_HR;
					end
				endcase
			end
			REGION_FIBRE: begin
				zsel_c2 = wall_s1 ? CFG_Z_FIB1 : CFG_Z_FIB0;
				if (!wall_s1) begin
					cx_c2 = 15'(fc);
					hx_c2 = fhw;
					hy_c2 = fhl;
				end else begin
					cy_c2 = fc;
					hx_c2 = fhl;
					hy_c2 = fhw;
				end
			end
			REGION_TIMING: begin
				zsel_c2 = CFG_Z_TOF;
				cx_c2   = TOF_X0 + 15'($signed({1'b0, bar_s1}) * TOF_PITCH);
				if (bar_s1 == TOF_BAR_LOW) cy_c2 = -TOF_Y;
				else if (bar_s1 == TOF_BAR_HIGH) cy_c2 = TOF_Y;
				hx_c2 = TOF_HW;
				hy_c2 = TOF_HY;
			end
			default: begin
				zsel_c2 = CFG_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			region_s2 <= region_s1;
			cx_s2     <= cx_c2;
			cy_s2     <= cy_c2;
			hx_s2     <= hx_c2;
			hy_s2     <= hy_c2;
			lx_s2     <= 14'(lx);
			stereo_s2 <= stereo_c2;
			neg_s2    <= neg_c2;
			zsel_s2   <= zsel_c2;
		end
	end

	// stage 3: stereo scaling product with rounding offset
	region_t             region_s3;
	logic signed [14:0]  cx_s3;
	logic signed [13:0]  cy_s3;
	logic [12:0]         hx_s3;
	logic [12:0]         hy_s3;
	logic signed [31:0]  prod_s3;
	logic                stereo_s3;
	logic                neg_s3;
	logic [RegIdxW-1:0]  zsel_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			region_s3 <= region_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
			hx_s3     <= hx_s2;
			hy_s3     <= hy_s2;
			prod_s3   <= 32'(lx_s2) * STEREO_MUL + STEREO_RND;
			stereo_s3 <= stereo_s2;
			neg_s3    <= neg_s2;
			zsel_s3   <= zsel_s2;
		end
	end

	// stage 4: plane z, disable check, output register
	logic signed [15:0]  stereo_v;
	logic [ZW-1:0]       z_c4;
	logic                hit_c4;
	logic signed [14:0]  cx_c4;
	logic signed [13:0]  cy_c4;

	logic signed [14:0]  cx_s4;
	logic signed [13:0]  cy_s4;
	logic [HrW-1:0]      hx_s4;
	logic [HrW-1:0]      hy_s4;
	logic [ZW-1:0]       z_s4;
	logic                hit_s4;
	region_t             region_s4;

	assign stereo_v = prod_s3[31:16];

	always_comb begin
		z_c4   = (zsel_s3 == CFG_NONE) ? '0 : zreg_q[zsel_s3];
		hit_c4 = region_s3 != REGION_NONE && z_c4 != '0;
		if (stereo_s3) begin
			cx_c4 = 15'(stereo_v);
			cy_c4 = neg_s3 ? 14'(-stereo_v) : 14'(stereo_v);
		end else begin
			cx_c4 = cx_s3;
			cy_c4 = cy_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			region_s4 <= region_s3;
			hit_s4    <= hit_c4;
			z_s4      <= hit_c4 ? z_c4 : '0;
			cx_s4     <= hit_c4 ? cx_c4 : '0;
			cy_s4     <= hit_c4 ? cy_c4 : '0;
			hx_s4     <= hit_c4 ? HrW'(hx_s3) : UNCONSTRAINED;
			hy_s4     <= hit_c4 ? HrW'(hy_s3) : UNCONSTRAINED;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {7'd0, z_s4, hy_s4, hx_s4, cy_s4, cx_s4};
	assign m_tuser  = {region_s4, hit_s4};

	// a valid hit always names a region and a configured plane
	a_hit_has_plane: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] != REGION_NONE && m_tdata[80:69] != '0)
		else $error("valid hit without region or plane z");

	// a rejected hit carries the unconstrained default
	a_miss_default: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[48:29] == UNCONSTRAINED
			&& m_tdata[68:49] == UNCONSTRAINED && m_tdata[28:0] == '0
			&& m_tdata[80:69] == '0)
		else $error("rejected hit lacks default geometry");

	// stereo half range only comes from the tracker
	a_stereo_tracker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tdata[48:29] == HrW'(STEREO_HR)
			|-> m_tuser[2:1] == REGION_TRACKER)
		else $error("stereo range outside tracker");

	// a stalled multiplier stage keeps its product
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !rdy3 |=> valid_s3 && $stable(prod_s3) && $stable(region_s3))
		else $error("stage 3 lost its item under stall");

endmodule

>>> tb/sv/hit_geometry_checker.sv
`timescale 1ns / 100ps

module hit_geometry_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [dhgd_pkg::InDataW-1:0]      s_tdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [dhgd_pkg::OutDataW-1:0]     m_tdata,
	input  logic [dhgd_pkg::OutUserW-1:0]     m_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dhgd_pkg::AddrW-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	input  logic [31:0]                       prdata,
	input  logic                              pready,
	output int                                fail_count,
	output int                                geom_outstanding
);
	import dhgd_pkg::*;

	localparam int CY_LO = CxW;
	localparam int HX_LO = CxW + CyW;
	localparam int HY_LO = HX_LO + HrW;
	localparam int Z_LO  = HY_LO + HrW;
	localparam int MAX_PRINTS = 200;

	typedef struct packed {
		logic [IdW-1:0]        chan;
		logic signed [CxW-1:0] cx;
		logic signed [CyW-1:0] cy;
		logic [HrW-1:0]        hx;
		logic [HrW-1:0]        hy;
		logic [ZW-1:0]         z;
		logic                  valid;
		region_t               region;
	} hit_geom_t;

	logic [ZW-1:0] plane_z [NumRegs];
	hit_geom_t     pending_geom [$];

	initial fail_count = 0;
	initial geom_outstanding = 0;

	task automatic report_mismatch(input string what, input int chan, input longint got,
			input longint want);
		if (fail_count < MAX_PRINTS)
			$display("%0t mismatch on %s, channel %0d: got %0d, expected %0d",
				$realtime, what, chan, got, want);
		fail_count++;
	endtask

	// floor((v * 46341 + 32768) / 65536); arithmetic shift gives the floor
	function automatic int stereo_scale(input int v);
		longint p;
		p = longint'(v) * 46341 + 32768;
		return int'(p >>> 16);
	endfunction

	function automatic int strip_mid(input int k);
		if (k < 10)
			return -6600 + 600 * k;
		if (k < 16)
			return -750 + 300 * (k - 10);
		return 1200 + 600 * (k - 16);
	endfunction

	// strip lengths are mirror symmetric about the wall centre
	function automatic int strip_half_length(input int k);
		int m;
		m = (k < 13) ? k : 25 - k;
		case (m)
			0: return 3725;
			1: return 4275;
			2: return 5375;
			3, 4: return 5925;
			5: return 6475;
			default: return 7025;
		endcase
	endfunction

	function automatic hit_geom_t decode_channel(input logic [IdW-1:0] id);
		hit_geom_t r;
		int n, station, straw, lx, s, wall, strip, hw, hl, bar, cx, cy, hx, hy;
		n = int'(id);
		cx = 0;
		cy = 0;
		hx = int'(UNCONSTRAINED);
		hy = int'(UNCONSTRAINED);
		r.chan = id;
		r.z = '0;
		r.valid = 1'b0;
		r.region = REGION_NONE;
		if (n >= 1 && n <= 1952) begin
			station = (n - 1) / 488;
			straw = (n - 1) % 488;
			lx = -4840 + 80 * (straw % 122);
			// odd sub-layers sit half a pitch over
			if ((straw / 122) % 2 == 1)
				lx = lx + 40;
			r.region = REGION_TRACKER;
			if (plane_z[station] != 0) begin
				r.z = plane_z[station];
				r.valid = 1'b1;
				case (station)
					0: begin
						cx = lx; cy = 0; hx = 40; hy = 4500;
					end
					1: begin
						cx = 0; cy = lx; hx = 4500; hy = 40;
					end
					default: begin
						s = stereo_scale(lx);
						cx = s;
						cy = (station == 2) ? s : -s;
						hx = stereo_scale(4500);
						hy = hx;
					end
				endcase
			end
		end else if (n >= 2001 && n <= 2052) begin
			wall = (n - 2001) / 26;
			strip = (n - 2001) % 26;
			r.region = REGION_FIBRE;
			if (plane_z[CFG_Z_FIB0 + wall] != 0) begin
				hw = (strip >= 10 && strip <= 15) ? 150 : 300;
				hl = strip_half_length(strip);
				r.z = plane_z[CFG_Z_FIB0 + wall];
				r.valid = 1'b1;
				if (wall == 0) begin
					cx = strip_mid(strip); cy = 0; hx = hw; hy = hl;
				end else begin
					cx = 0; cy = strip_mid(strip); hx = hl; hy = hw;
				end
			end
		end else if (n >= 2053 && n <= 2070) begin
			bar = n - 2053;
			r.region = REGION_TIMING;
			if (plane_z[CFG_Z_TOF] != 0) begin
				r.z = plane_z[CFG_Z_TOF];
				r.valid = 1'b1;
				cx = -9600 + 1200 * bar;
				cy = (bar == 8) ? -7200 : ((bar == 9) ? 7200 : 0);
				hx = 600;
				hy = 1000;
			end
		end
		r.cx = cx[CxW-1:0];
		r.cy = cy[CyW-1:0];
		r.hx = hx[HrW-1:0];
		r.hy = hy[HrW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_geom_t want, got;
		int idx;
		if (!arst_n) begin
			for (int k = 0; k < NumRegs; k++)
				plane_z[k] <= '0;
			pending_geom.delete();
			geom_outstanding = 0;
		end else begin
			idx = int'(paddr[AddrW-1:2]);
			if (psel && penable && pready && idx < NumRegs) begin
				if (pwrite)
					plane_z[idx] <= pwdata[ZW-1:0];
				else if (prdata[ZW-1:0] !== plane_z[idx])
					report_mismatch("register readback", idx, prdata[ZW-1:0], plane_z[idx]);
			end

			// compare before enqueuing; nothing can come out in the cycle it went in
			if (m_tvalid && m_tready) begin
				if (pending_geom.size() == 0) begin
					report_mismatch("result with nothing outstanding", -1, m_tdata[CxW-1:0], 0);
				end else begin
					want = pending_geom.pop_front();
					got.cx = $signed(m_tdata[CxW-1:0]);
					got.cy = $signed(m_tdata[CY_LO +: CyW]);
					got.hx = m_tdata[HX_LO +: HrW];
					got.hy = m_tdata[HY_LO +: HrW];
					got.z = m_tdata[Z_LO +: ZW];
					got.valid = m_tuser[0];
					got.region = region_t'(m_tuser[2:1]);
					if (got.cx !== want.cx)
						report_mismatch("centre_x", want.chan, int'(got.cx), int'(want.cx));
					if (got.cy !== want.cy)
						report_mismatch("centre_y", want.chan, int'(got.cy), int'(want.cy));
					if (got.hx !== want.hx)
						report_mismatch("half_range_x", want.chan, got.hx, want.hx);
					if (got.hy !== want.hy)
						report_mismatch("half_range_y", want.chan, got.hy, want.hy);
					if (got.z !== want.z)
						report_mismatch("plane_z", want.chan, got.z, want.z);
					if (got.valid !== want.valid)
						report_mismatch("hit_valid", want.chan, got.valid, want.valid);
					if (got.region !== want.region)
						report_mismatch("region", want.chan, got.region, want.region);
				end
			end

			if (s_tvalid && s_tready)
				pending_geom.insert(pending_geom.size(), decode_channel(s_tdata[IdW-1:0]));
			geom_outstanding = pending_geom.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import dhgd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 150;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 110;

	logic                 clk;
	logic                 arst_n;
	logic [InDataW-1:0]   s_tdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [OutDataW-1:0]  m_tdata;
	logic [OutUserW-1:0]  m_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrW-1:0]     paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	int fail_count;
	int geom_outstanding;

	bit send_gaps;
	bit sink_gaps;
	bit hold_stretch;

	logic [ZW-1:0] plane_setting [NumRegs];

	detector_hit_geometry_decode dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	hit_geometry_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tdata          (s_tdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.fail_count       (fail_count),
		.geom_outstanding (geom_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ZW-1:0] pick_plane_z();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 40)
			return '1;
		if (r < 50)
			return ZW'(1);
		return ZW'($urandom_range(1, 4095));
	endfunction

	// mostly channels that map to a module, some of the whole id space
	function automatic logic [IdW-1:0] pick_channel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return IdW'($urandom_range(TRK_FIRST, TRK_LAST));
		if (r < 65)
			return IdW'($urandom_range(FIB_FIRST, FIB_LAST));
		if (r < 80)
			return IdW'($urandom_range(TOF_FIRST, TOF_LAST));
		return IdW'($urandom_range(0, 4095));
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic apb_access(input logic wr, input logic [RegIdxW-1:0] idx,
			input logic [ZW-1:0] z);
		logic [31:0] junk;
		junk = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wr ? {junk[31:ZW], z} : junk;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_planes();
		for (int k = 0; k < NumRegs; k++) begin
			apb_access(1'b1, k[RegIdxW-1:0], plane_setting[k]);
			apb_access(1'b0, k[RegIdxW-1:0], '0);
		end
	endtask

	// call at a falling edge; returns at a falling edge with the item taken
	task automatic push_channel(input logic [IdW-1:0] id, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(InDataW-IdW){1'b0}}, id};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (geom_outstanding != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// receiver side
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_stretch) begin
				hold_stretch = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (sink_gaps && $urandom_range(0, 99) < 30) begin
				m_tready <= 1'b0;
				repeat (pick_gap() - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [IdW-1:0] directed [$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		hold_stretch = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// second fibre wall off so its disabled path shows up early
		plane_setting[CFG_Z_TRK0] = ZW'(1);
		plane_setting[CFG_Z_TRK1] = '1;
		plane_setting[CFG_Z_TRK2] = ZW'(2048);
		plane_setting[CFG_Z_TRK3] = ZW'(100);
		plane_setting[CFG_Z_FIB0] = '1;
		plane_setting[CFG_Z_FIB1] = '0;
		plane_setting[CFG_Z_TOF] = ZW'(1);
		program_planes();
		// writes past the last register must leave everything alone
		apb_access(1'b1, CFG_NONE, '1);

		// station edges, staggered layers, stereo signs, strip table ends and
		// the narrow strips, the two offset bars, and the gaps in the channel map
		directed = {12'd0, 12'd1, 12'd123, 12'd488, 12'd489, 12'd976, 12'd977,
			12'd1100, 12'd1464, 12'd1465, 12'd1952, 12'd1953, 12'd2000, 12'd2001,
			12'd2011, 12'd2016, 12'd2026, 12'd2027, 12'd2052, 12'd2053, 12'd2061,
			12'd2062, 12'd2070, 12'd2071, 12'd4095};
		foreach (directed[i])
			push_channel(directed[i], 0);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int k = 0; k < NumRegs; k++) begin
				case (ph)
					0: plane_setting[k] = '1;
					1: plane_setting[k] = ZW'(1);
					2: plane_setting[k] = '0;
					default: plane_setting[k] = pick_plane_z();
				endcase
			end
			program_planes();
			send_gaps = (ph % 3) != 1;
			sink_gaps = (ph % 4) != 3;
			// one phase runs back to back into a receiver that holds off
			if (ph == 1)
				hold_stretch = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				push_channel(pick_channel(),
					(send_gaps && $urandom_range(0, 99) < 35) ? pick_gap() : 0);
			drain_results();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && geom_outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
